// ===== rtl/met_pkg.sv =====
// met_pkg: item types, register indexes and fixed-point helpers for the
// escape-time pixel engine; no dependencies
package met_pkg;

    localparam int COLOR_BITS = 5;
    localparam int IDX_BITS   = 3;

    localparam logic [IDX_BITS-1:0] REG_X_LEFT   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_Y_TOP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_X_STEP   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [31:0] X_LEFT_RST   = -32'sd590558003;
    localparam logic signed [31:0] Y_TOP_RST    = 32'sd375809638;
    localparam logic signed [31:0] X_STEP_RST   = 32'sd2768241;
    localparam logic signed [31:0] Y_STEP_RST   = -32'sd2936013;
    localparam logic [15:0]        MAX_ITER_RST = 16'd50;

    localparam logic signed [35:0] Q36_MAX    = 36'sh7_FFFF_FFFF;
    localparam logic signed [35:0] Q36_MIN    = 36'sh8_0000_0000;
    localparam logic signed [31:0] Q32_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q32_MIN    = 32'sh8000_0000;
    // 16.0 in Q8.28
    localparam logic signed [35:0] ESC_LIMIT  = 36'sh1_0000_0000;

    typedef struct packed {
        logic [8:0] column;
        logic [7:0] row;
    } pix_in_t;

    typedef struct packed {
        logic [15:0]           iterations;
        logic                  inside_res;
        logic [COLOR_BITS-1:0] color;
    } pix_out_t;

    function automatic logic signed [35:0] sat36_37(input logic signed [36:0] v);
        logic signed [35:0] r;
        if (v[36] != v[35]) begin
            r = v[36] ? Q36_MIN : Q36_MAX;
        end else begin
            r = $signed(v[35:0]);
        end
        return r;
    endfunction

    function automatic logic signed [35:0] sat36_45(input logic signed [44:0] v);
        logic signed [35:0] r;
        if (v[44:35] == {10{v[44]}}) begin
            r = $signed(v[35:0]);
        end else begin
            r = v[44] ? Q36_MIN : Q36_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32_56(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v[55:31] == {25{v[55]}}) begin
            r = $signed(v[31:0]);
        end else begin
            r = v[55] ? Q32_MIN : Q32_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// mandelbrot_escape_time_pixel: escape-time pixel engine, one pixel at a time
// steps: CX, CY and C2 set up c, then each iteration runs U0, U1, V0, V1, W0, W1 and W2;
// six of the seven iteration states use the shared 36x19 multiplier; DONE hands out the result
// a new pixel is taken only once the last one is handed out: s_ready is low while a pixel is computed
// reset (aresetn, synchronous): registers to power-up view, idle, no result held
module mandelbrot_escape_time_pixel
    import met_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pix_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pix_out_t            m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CX   = 4'd1;
    localparam logic [3:0] ST_CY   = 4'd2;
    localparam logic [3:0] ST_C2   = 4'd3;
    localparam logic [3:0] ST_U0   = 4'd4;
    localparam logic [3:0] ST_U1   = 4'd5;
    localparam logic [3:0] ST_V0   = 4'd6;
    localparam logic [3:0] ST_V1   = 4'd7;
    localparam logic [3:0] ST_W0   = 4'd8;
    localparam logic [3:0] ST_W1   = 4'd9;
    localparam logic [3:0] ST_W2   = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0]         state_reg;
    logic signed [31:0] x_left_reg, y_top_reg, x_step_reg, y_step_reg;
    logic [15:0]        max_iter_reg;
    logic [8:0]         col_reg;
    logic [7:0]         row_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [35:0] x_reg, y_reg, u_reg, v_reg, w_reg;
    logic signed [54:0] prod_reg, acc_reg;
    logic [15:0]        k_reg;
    logic               inside_reg;
    logic               m_valid_reg;
    pix_out_t           m_data_reg;

    logic signed [35:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [54:0] prod_next;
    logic signed [72:0] prod_sum;
    logic signed [35:0] mul_q;
    logic signed [35:0] x2;
    logic signed [35:0] uv_sat, umv_sat, x_new, y_new;
    logic               escape;
    logic [16:0]        k_inc;
    logic signed [31:0] cx_new, cy_new;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // doubled x for the cross term
    assign x2 = sat36_37($signed({x_reg, 1'b0}));

    // operand select for the shared multiplier, low 18 bits first then high part
    always_comb begin
        case (state_reg)
            ST_CX: begin
                mul_a = 36'(x_step_reg);
                mul_b = $signed({10'd0, col_reg});
            end
            ST_CY: begin
                mul_a = 36'(y_step_reg);
                mul_b = $signed({11'd0, row_reg});
            end
            ST_U0: begin
                mul_a = x_reg;
                mul_b = $signed({1'b0, x_reg[17:0]});
            end
            ST_U1: begin
                mul_a = x_reg;
                mul_b = $signed({x_reg[35], x_reg[35:18]});
            end
            ST_V0: begin
                mul_a = y_reg;
                mul_b = $signed({1'b0, y_reg[17:0]});
            end
            ST_V1: begin
                mul_a = y_reg;
                mul_b = $signed({y_reg[35], y_reg[35:18]});
            end
            ST_W0: begin
                mul_a = x2;
                mul_b = $signed({1'b0, y_reg[17:0]});
            end
            ST_W1: begin
                mul_a = x2;
                mul_b = $signed({y_reg[35], y_reg[35:18]});
            end
            default: begin
                mul_a = x_reg;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // combine the two partial products, floor shift by 28, saturate
    assign prod_sum = 73'(acc_reg) + (73'(prod_reg) <<< 18);
    assign mul_q    = sat36_45($signed(prod_sum[72:28]));

    assign uv_sat  = sat36_37(37'(u_reg) + 37'(v_reg));
    assign escape  = (uv_sat > ESC_LIMIT);
    assign umv_sat = sat36_37(37'(u_reg) - 37'(v_reg));
    assign x_new   = sat36_37(37'(umv_sat) + 37'(cx_reg));
    assign y_new   = sat36_37(37'(w_reg) + 37'(cy_reg));
    assign k_inc   = {1'b0, k_reg} + 17'd1;

    assign cx_new = sat32_56(56'(x_left_reg) + 56'(prod_reg));
    assign cy_new = sat32_56(56'(y_top_reg) + 56'(prod_reg));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            x_left_reg   <= X_LEFT_RST;
            y_top_reg    <= Y_TOP_RST;
            x_step_reg   <= X_STEP_RST;
            y_step_reg   <= Y_STEP_RST;
            max_iter_reg <= MAX_ITER_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_X_LEFT:   x_left_reg   <= $signed(cfg_data);
                REG_Y_TOP:    y_top_reg    <= $signed(cfg_data);
                REG_X_STEP:   x_step_reg   <= $signed(cfg_data);
                REG_Y_STEP:   y_step_reg   <= $signed(cfg_data);
                REG_MAX_ITER: max_iter_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in the done state the result register is loaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        col_reg   <= s_data.column;
                        row_reg   <= s_data.row;
                        state_reg <= ST_CX;
                    end
                end
                ST_CX: state_reg <= ST_CY;
                ST_CY: begin
                    cx_reg    <= cx_new;
                    state_reg <= ST_C2;
                end
                ST_C2: begin
                    cy_reg <= cy_new;
                    x_reg  <= 36'(cx_reg);
                    // y picks up cy on entry to the loop
                    w_reg  <= '0;
                    k_reg  <= '0;
                    if (max_iter_reg == '0) begin
                        inside_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_U0;
                    end
                end
                ST_U0: begin
                    y_reg     <= y_new;
                    state_reg <= ST_U1;
                end
                ST_U1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_V0;
                end
                ST_V0: begin
                    u_reg     <= mul_q;
                    state_reg <= ST_V1;
                end
                ST_V1: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_W0;
                end
                ST_W0: begin
                    v_reg     <= mul_q;
                    state_reg <= ST_W1;
                end
                ST_W1: begin
                    acc_reg <= prod_reg;
                    if (escape) begin
                        inside_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_W2;
                    end
                end
                ST_W2: begin
                    w_reg <= mul_q;
                    x_reg <= x_new;
                    k_reg <= k_inc[15:0];
                    if (k_inc >= {1'b0, max_iter_reg}) begin
                        inside_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end else begin
                        state_reg <= ST_U0;
                    end
                end
                ST_DONE: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.iterations <= k_reg;
                        m_data_reg.inside_res <= inside_reg;
                        m_data_reg.color      <= inside_reg ? COLOR_BITS'(1)
                                                            : k_reg[COLOR_BITS-1:0];
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
